// ----- rtl/core/rsa_pkg.sv -----
// Shared types and constants for the reference-counted slot allocator.
// Holds request/result field widths, opcode and status codes and parameter defaults.
// No dependencies.
package rsa_pkg;

    // Parameter defaults
    localparam int SLOTS_DEF      = 1024;
    localparam int COUNT_BITS_DEF = 16;

    // Field widths fixed by the stream format
    localparam int CFG_W      = 11;   // slot_count register
    localparam int OP_W       = 2;
    localparam int SLOT_FW    = 10;   // slot_index / granted_slot
    localparam int CNT_OUT_W  = 16;   // new_count
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 16;   // 12 bits of fields, padded to 2 bytes
    localparam int M_TDATA_W  = 32;   // 29 bits of fields, padded to 4 bytes
    localparam int M_PAD_W    = M_TDATA_W - (STATUS_W + SLOT_FW + CNT_OUT_W + 1);
    localparam int CFG_MAX    = 1024; // slot_count after reset, before clamping

    // Opcodes (code 3 is not an operation and is answered with zeros)
    typedef logic [OP_W-1:0] opcode_t;
    localparam opcode_t OP_ALLOC = 2'd0;
    localparam opcode_t OP_REF   = 2'd1;
    localparam opcode_t OP_DEREF = 2'd2;

    // Result status
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_COUNT = 2'd3
    } status_t;

endpackage

// ----- rtl/core/rsa_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one read port with registered data.
// Used for the reference counts and for the free ring.
// Depends on nothing.
module rsa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next enabled read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/refcounted_slot_allocator_top.sv -----
// Top level of the reference-counted slot allocator: handshakes, pool pointers,
// read-modify-write stage with forwarding, result register. Uses rsa_pkg and rsa_ram.
//
// Usage:
//   s_ channel takes one request per accept: opcode (alloc, ref, deref) and slot_index.
//   m_ channel returns exactly one result per request, in request order.
//   cfg_ channel writes slot_count; a write rebuilds the pool (free list 0..count-1,
//   all counts zero). Write it only while no request is in flight.
// Pipeline: RAM stage, then the result register on m_. Throughput: one request per
// cycle while m_ is not stalled. Each request does one count read-modify-write and at
// most one free-ring access; both RAMs have a registered read, and a request that hits
// the entry written by the request before it takes the forwarded value.
// Reset: slot_count = min(SLOTS, 1024), pool empty of references. No clearing pass:
// count entries at or above the fresh-slot counter read as zero, so the block takes
// requests right after reset.
// Stall: when m_tready is low the result waits in its register, the RAM stage holds
// its request, and s_tready drops only once both are occupied.
module refcounted_slot_allocator_top
    import rsa_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [1:0] opcode, [11:2] slot_index
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // [1:0] status, [11:2] granted_slot,
                                           // [27:12] new_count, [28] slot_freed
    // slot_count write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int SW = $clog2(SLOTS);
    localparam int PW = (SLOTS >= 2047) ? CFG_W : $clog2(SLOTS + 1);
    localparam int RESET_CNT = (SLOTS < CFG_MAX) ? SLOTS : CFG_MAX;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    typedef struct packed {
        logic          wrap;
        logic [SW-1:0] pos;
    } ring_ptr_t;

    function automatic ring_ptr_t ring_adv(input ring_ptr_t p);
        ring_ptr_t r;
        if (p.pos == SW'(SLOTS - 1)) begin
            r.pos  = '0;
            r.wrap = ~p.wrap;
        end else begin
            r.pos  = p.pos + SW'(1);
            r.wrap = p.wrap;
        end
        return r;
    endfunction

    // Request fields
    opcode_t            s_op;
    logic [SLOT_FW-1:0] s_idx;
    assign s_op  = opcode_t'(s_tdata[OP_W-1:0]);
    assign s_idx = s_tdata[OP_W +: SLOT_FW];

    // Pool state
    logic [PW-1:0] slot_count_reg, slot_count_next;
    logic [PW-1:0] fresh_reg, fresh_next;
    ring_ptr_t     head_reg, head_next;
    ring_ptr_t     tail_reg, tail_next;

    // RAM stage
    logic                  p1_valid_reg, p1_valid_next;
    opcode_t               p1_op_reg;
    logic [SLOT_FW-1:0]    p1_idx_reg;
    logic                  cnt_fwd_hit_reg;
    logic [COUNT_BITS-1:0] cnt_fwd_data_reg;
    logic                  ring_fwd_hit_reg;
    logic [SW-1:0]         ring_fwd_data_reg;

    // Result register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // RAM ports
    logic                  cnt_we;
    logic [SW-1:0]         cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [COUNT_BITS-1:0] cnt_rdata;
    logic                  ring_we;
    logic [SW-1:0]         ring_rdata;

    // Handshake
    logic s_fire, cfg_fire, out_free, p1_go;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign out_free  = ~m_tvalid_reg | m_tready;
    assign p1_go     = p1_valid_reg & out_free;
    assign s_tready  = ~p1_valid_reg | out_free;
    assign s_fire    = s_tvalid & s_tready;

    // Read-modify-write decision for the request in the RAM stage
    status_t               r_status;
    logic [SW-1:0]         r_granted;
    logic [COUNT_BITS-1:0] r_cnt;
    logic                  r_freed;
    logic                  fresh_adv, head_adv, ring_push;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic [SW-1:0]         ring_slot;
    logic                  ring_empty, ring_full;
    logic [CFG_W-1:0]      idx_ext;

    assign idx_ext    = CFG_W'(p1_idx_reg);
    assign ring_empty = (head_reg == tail_reg);
    assign ring_full  = (head_reg.pos == tail_reg.pos) && (head_reg.wrap != tail_reg.wrap);
    assign ring_slot  = ring_fwd_hit_reg ? ring_fwd_data_reg : ring_rdata;

    // Entries at or above the fresh counter were never handed out since init: zero
    always_comb begin
        if (idx_ext >= CFG_W'(fresh_reg)) begin
            cur_cnt = '0;
        end else if (cnt_fwd_hit_reg) begin
            cur_cnt = cnt_fwd_data_reg;
        end else begin
            cur_cnt = cnt_rdata;
        end
    end

    always_comb begin
        r_status  = ST_OK;
        r_granted = '0;
        r_cnt     = '0;
        r_freed   = 1'b0;
        fresh_adv = 1'b0;
        head_adv  = 1'b0;
        ring_push = 1'b0;
        cnt_we    = 1'b0;
        cnt_waddr = SW'(p1_idx_reg);
        cnt_wdata = cur_cnt;
        unique case (p1_op_reg)
            OP_ALLOC: begin
                if (CFG_W'(fresh_reg) < CFG_W'(slot_count_reg)) begin
                    fresh_adv = 1'b1;
                    r_granted = SW'(fresh_reg);
                end else if (!ring_empty) begin
                    head_adv  = 1'b1;
                    r_granted = ring_slot;
                end else begin
                    r_status = ST_EMPTY;
                end
                if (r_status == ST_OK) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = r_granted;
                    cnt_wdata = CNT_ONE;
                    r_cnt     = CNT_ONE;
                end
            end
            OP_REF, OP_DEREF: begin
                if (idx_ext >= CFG_W'(slot_count_reg)) begin
                    r_status = ST_RANGE;
                end else if (cur_cnt == '0) begin
                    r_status = ST_COUNT;
                end else if (p1_op_reg == OP_REF) begin
                    if (cur_cnt == CNT_MAX) begin
                        r_status = ST_COUNT;
                        r_cnt    = cur_cnt;
                    end else begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cur_cnt + CNT_ONE;
                        r_cnt     = cur_cnt + CNT_ONE;
                    end
                end else begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cur_cnt - CNT_ONE;
                    r_cnt     = cur_cnt - CNT_ONE;
                    if (cur_cnt == CNT_ONE) begin
                        r_freed   = 1'b1;
                        ring_push = ~ring_full;
                    end
                end
            end
            default: begin
                // not an operation: answer zeros, touch nothing
            end
        endcase
    end

    // Write enables qualified by the stage advancing
    logic cnt_we_go;
    assign cnt_we_go = cnt_we & p1_go;
    assign ring_we   = ring_push & p1_go;

    // Pool pointer updates; a config write rebuilds the pool
    always_comb begin
        slot_count_next = slot_count_reg;
        fresh_next      = fresh_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        if (cfg_fire) begin
            if (32'(cfg_data) > 32'(SLOTS)) begin
                slot_count_next = PW'(SLOTS);
            end else begin
                slot_count_next = PW'(cfg_data);
            end
            fresh_next = '0;
            head_next  = '0;
            tail_next  = '0;
        end else if (p1_go) begin
            if (fresh_adv) begin
                fresh_next = fresh_reg + PW'(1);
            end
            if (head_adv) begin
                head_next = ring_adv(head_reg);
            end
            if (ring_push) begin
                tail_next = ring_adv(tail_reg);
            end
        end
    end

    // Stage valids
    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (s_fire) begin
            p1_valid_next = 1'b1;
        end else if (p1_go) begin
            p1_valid_next = 1'b0;
        end
        m_tvalid_next = m_tvalid_reg;
        if (p1_go) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= PW'(RESET_CNT);
            fresh_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            p1_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            slot_count_reg <= slot_count_next;
            fresh_reg      <= fresh_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            p1_valid_reg   <= p1_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Request capture with forwarding of writes landing on the same edge
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_op_reg         <= s_op;
            p1_idx_reg        <= s_idx;
            cnt_fwd_hit_reg   <= cnt_we_go && (cnt_waddr == SW'(s_idx));
            cnt_fwd_data_reg  <= cnt_wdata;
            ring_fwd_hit_reg  <= ring_we && (tail_reg.pos == head_next.pos);
            ring_fwd_data_reg <= SW'(p1_idx_reg);
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (p1_go) begin
            m_tdata_reg <= {M_PAD_W'(0), r_freed, CNT_OUT_W'(r_cnt),
                            SLOT_FW'(r_granted), r_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Reference counts
    rsa_ram #(
        .DEPTH (SLOTS),
        .WIDTH (COUNT_BITS)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we_go),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (s_fire),
        .raddr (SW'(s_idx)),
        .rdata (cnt_rdata)
    );

    // Free ring of returned slots
    rsa_ram #(
        .DEPTH (SLOTS),
        .WIDTH (SW)
    ) u_ring_ram (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (tail_reg.pos),
        .wdata (SW'(p1_idx_reg)),
        .re    (s_fire),
        .raddr (head_next.pos),
        .rdata (ring_rdata)
    );

    // Fresh counter never passes the pool size
    a_fresh_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CFG_W'(fresh_reg) <= CFG_W'(slot_count_reg))
        else $error("fresh slot counter beyond slot_count");

    // A slot is only pushed when the ring has room
    a_ring_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_we |-> !ring_full)
        else $error("free ring overflow");

    // A stalled RAM stage keeps its request
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !out_free) |=> (p1_valid_reg && $stable(p1_idx_reg)
                                         && $stable(p1_op_reg)))
        else $error("RAM stage lost its request under stall");

endmodule

// ----- bench/slot_pool_checker.sv -----
// Checker for the reference-counted slot allocator: watches the request, result
// and slot_count channels, keeps its own copy of the pool and compares each result.
// Depends on rsa_pkg.
module slot_pool_checker
    import rsa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [1:0] opcode, [11:2] slot_index
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,  // [1:0] status, [11:2] granted_slot,
                                           // [27:12] new_count, [28] slot_freed
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    output int unsigned          fail_count,
    output int unsigned          outstanding,
    output int unsigned          checked_count,
    output int unsigned          freed_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CNT_OUT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        status_t              status;
        logic [SLOT_FW-1:0]   slot;
        logic [CNT_OUT_W-1:0] count;
        logic                 freed;
    } pool_answer_t;

    // Own copy of the pool
    logic [CNT_OUT_W-1:0] ref_cnt   [SLOTS_DEF];
    logic [SLOT_FW-1:0]   free_slots[SLOTS_DEF];
    logic [CFG_W-1:0]     ring_rd;   // counts modulo 2*SLOTS
    logic [CFG_W-1:0]     ring_wr;
    logic [CFG_W-1:0]     next_fresh;
    logic [CFG_W-1:0]     pool_size;

    pool_answer_t answer_q[$];
    pool_answer_t oldest;
    int unsigned  errs      = 0;
    int unsigned  n_checked = 0;
    int unsigned  n_freed   = 0;

    assign fail_count    = errs;
    assign checked_count = n_checked;
    assign freed_seen    = n_freed;

    // Empty the pool and set its size, clamped to the number of slots
    function automatic void rebuild_pool(logic [CFG_W-1:0] size);
        for (int i = 0; i < SLOTS_DEF; i++) begin
            ref_cnt[i]    = '0;
            free_slots[i] = '0;
        end
        ring_rd    = '0;
        ring_wr    = '0;
        next_fresh = '0;
        pool_size  = (size > CFG_W'(SLOTS_DEF)) ? CFG_W'(SLOTS_DEF) : size;
    endfunction

    // Apply one request to the pool copy and return the answer it should get
    function automatic pool_answer_t apply_pool_request(opcode_t op, logic [SLOT_FW-1:0] idx);
        pool_answer_t         r;
        logic [SLOT_FW-1:0]   s;
        logic [CNT_OUT_W-1:0] c;
        logic                 got;
        r = '{status: ST_OK, slot: '0, count: '0, freed: 1'b0};
        case (op)
            OP_ALLOC: begin
                got = 1'b1;
                s   = '0;
                // never-used slots first, then the oldest returned one
                if (next_fresh < pool_size) begin
                    s          = next_fresh[SLOT_FW-1:0];
                    next_fresh = next_fresh + 1'b1;
                end else if (ring_rd != ring_wr) begin
                    s       = free_slots[ring_rd[SLOT_FW-1:0]];
                    ring_rd = ring_rd + 1'b1;
                end else begin
                    got = 1'b0;
                end
                if (got) begin
                    ref_cnt[s] = CNT_OUT_W'(1);
                    r.slot     = s;
                    r.count    = CNT_OUT_W'(1);
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            OP_REF, OP_DEREF: begin
                if ({1'b0, idx} >= pool_size) begin
                    r.status = ST_RANGE;
                end else begin
                    c = ref_cnt[idx];
                    if (c == 0) begin
                        r.status = ST_COUNT;
                    end else if (op == OP_REF) begin
                        if (c == COUNT_MAX) r.status = ST_COUNT;
                        else c = c + 1'b1;
                    end else begin
                        c = c - 1'b1;
                        // last reference gone: slot goes to the tail of the ring
                        if (c == 0) begin
                            if (CFG_W'(ring_wr - ring_rd) < CFG_W'(SLOTS_DEF)) begin
                                free_slots[ring_wr[SLOT_FW-1:0]] = idx;
                                ring_wr = ring_wr + 1'b1;
                            end
                            r.freed = 1'b1;
                        end
                    end
                    ref_cnt[idx] = c;
                    r.count      = c;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic compare_answer(pool_answer_t want, logic [M_TDATA_W-1:0] word);
        logic [STATUS_W-1:0]  got_status;
        logic [SLOT_FW-1:0]   got_slot;
        logic [CNT_OUT_W-1:0] got_count;
        logic                 got_freed;
        got_status = word[STATUS_W-1:0];
        got_slot   = word[STATUS_W +: SLOT_FW];
        got_count  = word[STATUS_W+SLOT_FW +: CNT_OUT_W];
        got_freed  = word[STATUS_W+SLOT_FW+CNT_OUT_W];
        if (got_status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            errs++;
        end
        if (got_slot != want.slot) begin
            $error("granted_slot: expected %0d, got %0d", want.slot, got_slot);
            errs++;
        end
        if (got_count != want.count) begin
            $error("new_count: expected %0d, got %0d", want.count, got_count);
            errs++;
        end
        if (got_freed != want.freed) begin
            $error("slot_freed: expected %0d, got %0d", want.freed, got_freed);
            errs++;
        end
    endtask

    // All channels sampled on the clock edge; results before new requests
    always @(posedge aclk) begin
        if (!aresetn) begin
            rebuild_pool(CFG_W'(CFG_MAX));
            answer_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) rebuild_pool(cfg_data);
            if (m_tvalid && m_tready) begin
                if (answer_q.size() == 0) begin
                    $error("result 0x%08h with no request waiting", m_tdata);
                    errs++;
                end else begin
                    oldest = answer_q.pop_front();
                    compare_answer(oldest, m_tdata);
                    n_checked++;
                    if (oldest.freed) n_freed++;
                end
            end
            if (s_tvalid && s_tready)
                answer_q.push_back(apply_pool_request(s_tdata[OP_W-1:0],
                                                      s_tdata[OP_W +: SLOT_FW]));
        end
        outstanding <= answer_q.size();
    end

endmodule

// ----- bench/tb_refcounted_slot_allocator_top.sv -----
// Testbench top for the reference-counted slot allocator: clock, reset, request and
// slot_count stimulus, result back-pressure and verdict. Uses rsa_pkg, slot_pool_checker.
module tb_refcounted_slot_allocator_top;
    import rsa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int      CLK_HALF     = 10;
    localparam int      RESET_CYCLES = 9;
    localparam int      SETTLE_TAIL  = 8;
    localparam int      CYCLE_LIMIT  = 1_000_000;
    localparam opcode_t OP_UNUSED    = 2'd3;     // not an operation, answered with zeros

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;       // [1:0] opcode, [11:2] slot_index
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;              // [1:0] status, [11:2] granted_slot,
                                                // [27:12] new_count, [28] slot_freed
    logic                 cfg_ready;

    int unsigned fail_count, outstanding, checked_count, freed_seen;
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    int unsigned pool_now  = CFG_MAX;
    int unsigned allocs_since_cfg = 0;
    int unsigned sent = 0;
    int unsigned sent_random = 0;
    int unsigned cfg_writes = 0;
    int unsigned cycle_no = 0;

    refcounted_slot_allocator_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    slot_pool_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count),
        .freed_seen    (freed_seen)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // One request, with a random gap in front; returns once s_tready reads high after an edge
    task automatic issue(opcode_t op, logic [SLOT_FW-1:0] idx);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-OP_W-SLOT_FW){1'b0}}, idx, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        if (op == OP_ALLOC) allocs_since_cfg++;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_pool_size(logic [CFG_W-1:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        pool_now  = (v > CFG_W'(SLOTS_DEF)) ? SLOTS_DEF : int'(v);
        allocs_since_cfg = 0;
        cfg_writes++;
    endtask

    // Mostly slots that have likely been handed out, now and then any index
    function automatic logic [SLOT_FW-1:0] pick_slot();
        int unsigned span;
        span = (allocs_since_cfg < pool_now) ? allocs_since_cfg : pool_now;
        if (span == 0 || $urandom_range(99) < 8) return SLOT_FW'($urandom);
        return SLOT_FW'($urandom_range(span - 1));
    endfunction

    task automatic random_phase(int unsigned n, int unsigned pool,
                                int unsigned gap, int unsigned stall);
        int unsigned pick;
        write_pool_size(CFG_W'(pool));
        gap_pct   = gap;
        stall_pct = stall;
        for (int unsigned i = 0; i < n; i++) begin
            // hold off mid-phase until the pipeline is empty
            if (i == n / 2) wait_idle();
            pick = $urandom_range(99);
            if (pick < 30)      issue(OP_ALLOC, SLOT_FW'($urandom));
            else if (pick < 62) issue(OP_REF, pick_slot());
            else if (pick < 97) issue(OP_DEREF, pick_slot());
            else                issue(OP_UNUSED, SLOT_FW'($urandom));
            sent_random++;
        end
    endtask

    initial begin
        int unsigned k;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero counts, opcode 3, top index, ring reuse, empty and
        // zero-sized pools, oversized slot_count
        issue(OP_DEREF, 10'd0);
        issue(OP_REF, 10'd1023);
        issue(OP_ALLOC, 10'h3FF);
        issue(OP_REF, 10'd0);
        issue(OP_DEREF, 10'd0);
        issue(OP_DEREF, 10'd0);
        issue(OP_DEREF, 10'd0);
        issue(OP_UNUSED, 10'd1023);
        write_pool_size(CFG_W'(2));
        issue(OP_ALLOC, 10'd0);
        issue(OP_ALLOC, 10'd0);
        issue(OP_ALLOC, 10'd0);
        issue(OP_REF, 10'd2);
        issue(OP_REF, 10'd1023);
        issue(OP_DEREF, 10'd1);
        issue(OP_ALLOC, 10'd0);
        issue(OP_DEREF, 10'd0);
        issue(OP_ALLOC, 10'd0);
        write_pool_size(CFG_W'(0));
        issue(OP_ALLOC, 10'd0);
        issue(OP_REF, 10'd0);
        issue(OP_DEREF, 10'd0);
        write_pool_size(CFG_W'(2047));
        issue(OP_REF, 10'd1023);
        issue(OP_ALLOC, 10'd0);

        // Single-slot churn: the same slot freed and handed out again and again
        write_pool_size(CFG_W'(1));
        gap_pct   = 21;
        stall_pct = 21;
        repeat (150) begin
            k = $urandom_range(2);
            issue(OP_ALLOC, SLOT_FW'($urandom));
            repeat (k) issue(OP_REF, 10'd0);
            repeat (k + 1) issue(OP_DEREF, 10'd0);
        end

        // Random traffic under each idling mix
        random_phase(220, 8, 0, 0);
        random_phase(220, SLOTS_DEF, 72, 0);
        random_phase(220, $urandom_range(2, 24), 0, 72);
        random_phase(220, 3, 21, 21);

        wait_idle();
        stall_pct = 0;
        repeat (SETTLE_TAIL) @(posedge aclk);

        $display("Covered %0d requests (%0d random) across %0d slot_count writes,",
                 sent, sent_random, cfg_writes);
        $display("slot reuse through the ring and empty pools; %0d results checked, %0d frees",
                 checked_count, freed_seen);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
